// ----- rtl/core/mipmap_box_filter_chain_top_macros.svh -----
// assertion macros for the mipmap filter chain checker
`ifndef MIPMAP_BOX_FILTER_CHAIN_TOP_MACROS_SVH
`define MIPMAP_BOX_FILTER_CHAIN_TOP_MACROS_SVH

// same-cycle implication, disabled while rst is high
`define MBF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while rst is high
`define MBF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/mbf_pkg.sv -----
// types and constants of the mipmap box filter chain
`default_nettype none

package mbf_pkg;

   localparam int unsigned PIX_W     = 32;
   localparam int unsigned CH_W      = 8;
   localparam int unsigned SUM_W     = 9;
   localparam int unsigned LEVEL_W   = 4;
   localparam int unsigned POS_W     = 10;
   localparam int unsigned CFG_W     = 4;
   localparam int unsigned CSR_IDX_W = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_LOG2  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEVELS = 2'd1;

   // register reset values
   localparam logic [CFG_W-1:0] SIZE_LOG2_RST  = 4'd8;
   localparam logic [CFG_W-1:0] MAX_LEVELS_RST = 4'd12;

   typedef struct packed {
      logic [CH_W-1:0] r;
      logic [CH_W-1:0] g;
      logic [CH_W-1:0] b;
   } rgb_type;

   typedef struct packed {
      logic [SUM_W-1:0] r;
      logic [SUM_W-1:0] g;
      logic [SUM_W-1:0] b;
   } pair_sum_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_in;
      logic             frame_start;
   } req_word_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [POS_W-1:0]   col;
      logic [POS_W-1:0]   row;
      logic [PIX_W-1:0]   color;
      logic               last;
   } rsp_word_type;

endpackage

`default_nettype wire

// ----- rtl/core/mbf_ram.sv -----
// generic single-write, single-read ram with registered read data
`default_nettype none

module mbf_ram #(
   parameter int unsigned WIDTH = 27,
   parameter int unsigned DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/mipmap_box_filter_chain_top.sv -----
// Mipmap chain builder: 2x2 box filter over a raster pixel stream, levels cascade.
// A word is accepted in idle and then takes a level step; each mip pixel it finishes adds
// a row-sum ram read and a result load, and the load waits while the result register is
// held by rsp_stall. The input stalls until a word has gone through all of its levels.
// Reset (synchronous): registers to defaults, level counters and pair holds cleared;
// the row-sum ram is not cleared, each entry is written on an even row before use.
`default_nettype none

module mipmap_box_filter_chain_top #(
   parameter int unsigned MAX_SIDE_LOG2 = 11,
   parameter int unsigned MAX_LEVELS    = 12
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire mbf_pkg::req_word_type         req_word,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output mbf_pkg::rsp_word_type              rsp_word,
   input  wire logic                          csr_we,
   input  wire logic [mbf_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [mbf_pkg::CFG_W-1:0]     csr_wdata
);

   localparam int unsigned LV_W  = $clog2(MAX_LEVELS);
   localparam int unsigned CW    = MAX_SIDE_LOG2;
   localparam int unsigned SW    = MAX_SIDE_LOG2 + 1;
   localparam int unsigned AW    = MAX_SIDE_LOG2;
   localparam int unsigned DEPTH = 1 << MAX_SIDE_LOG2;
   localparam int unsigned PSW   = $bits(mbf_pkg::pair_sum_type);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_STEP = 3'b010,
      ST_READ = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [mbf_pkg::CFG_W-1:0] size_log2_ff, max_levels_ff;
   logic [CW-1:0]             col_ff [MAX_LEVELS];
   logic [CW-1:0]             row_ff [MAX_LEVELS];
   mbf_pkg::rgb_type          hold_ff [MAX_LEVELS];

   mbf_pkg::rgb_type          cur_ff, cur_in;
   logic [LV_W-1:0]           lv_ff, lv_in;
   mbf_pkg::pair_sum_type     ps_ff;
   logic [mbf_pkg::POS_W-1:0] out_col_ff, out_row_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   mbf_pkg::rsp_word_type     rsp_word_ff, rsp_word_in;

   logic req_accept, restart_cfg, restart;
   logic rsp_free, rsp_load;
   logic ram_we, ram_re;
   logic [AW-1:0] ram_addr;
   mbf_pkg::pair_sum_type ram_rdata;

   // effective configuration
   logic [mbf_pkg::CFG_W-1:0] s_eff, ml_eff;
   always_comb begin
      s_eff = (size_log2_ff > mbf_pkg::CFG_W'(MAX_SIDE_LOG2)) ?
              mbf_pkg::CFG_W'(MAX_SIDE_LOG2) : size_log2_ff;
      priority if (max_levels_ff == '0) begin
         ml_eff = mbf_pkg::CFG_W'(1);
      end else if (max_levels_ff > mbf_pkg::CFG_W'(MAX_LEVELS)) begin
         ml_eff = mbf_pkg::CFG_W'(MAX_LEVELS);
      end else begin
         ml_eff = max_levels_ff;
      end
   end

   // handshakes and restart
   assign req_stall   = (state_ff != ST_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign restart_cfg = csr_we && ((csr_index == mbf_pkg::CSR_SIZE_LOG2) ||
                                   (csr_index == mbf_pkg::CSR_MAX_LEVELS));
   assign restart     = restart_cfg || (req_accept && req_word.frame_start);
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;

   // current level position and counter advance
   logic [4:0]    lv5, sl5, sh5;
   logic [3:0]    side_log;
   logic [SW-1:0] side, c_inc, r_inc;
   logic [CW-1:0] c_cur, r_cur, col_next, row_next;
   logic          term;
   mbf_pkg::rgb_type      hold_cur;
   mbf_pkg::pair_sum_type ps;
   always_comb begin
      lv5      = 5'(lv_ff);
      sl5      = 5'(s_eff) - lv5;
      side_log = sl5[3:0];
      side     = SW'(1) << side_log;
      c_cur    = ({1'b0, col_ff[lv_ff]} >= side) ? '0 : col_ff[lv_ff];
      r_cur    = ({1'b0, row_ff[lv_ff]} >= side) ? '0 : row_ff[lv_ff];
      c_inc    = {1'b0, c_cur} + SW'(1);
      r_inc    = {1'b0, r_cur} + SW'(1);
      if (c_inc >= side) begin
         col_next = '0;
         row_next = (r_inc >= side) ? '0 : r_inc[CW-1:0];
      end else begin
         col_next = c_inc[CW-1:0];
         row_next = r_cur;
      end
      term     = (side_log == 4'd0) || ((lv5 + 5'd1) >= 5'(ml_eff));
      hold_cur = hold_ff[lv_ff];
      ps.r     = mbf_pkg::SUM_W'(hold_cur.r) + mbf_pkg::SUM_W'(cur_ff.r);
      ps.g     = mbf_pkg::SUM_W'(hold_cur.g) + mbf_pkg::SUM_W'(cur_ff.g);
      ps.b     = mbf_pkg::SUM_W'(hold_cur.b) + mbf_pkg::SUM_W'(cur_ff.b);
      // each level owns a power-of-two window of the row-sum ram
      sh5      = 5'(MAX_SIDE_LOG2 - 1) - lv5;
      ram_addr = (AW'(1) << sh5) | AW'(c_cur >> 1);
   end

   // look ahead at the next level to flag the final result
   logic [LV_W-1:0] nx;
   logic [4:0]      nx5, nsl5;
   logic [SW-1:0]   nside;
   logic            nx_c_odd, nx_r_odd, more;
   always_comb begin
      nx       = lv_ff + LV_W'(1);
      nx5      = lv5 + 5'd1;
      nsl5     = 5'(s_eff) - nx5;
      nside    = SW'(1) << nsl5[3:0];
      nx_c_odd = ({1'b0, col_ff[nx]} < nside) && col_ff[nx][0];
      nx_r_odd = ({1'b0, row_ff[nx]} < nside) && row_ff[nx][0];
      more     = (nsl5 != 5'd0) && ((nx5 + 5'd1) < 5'(ml_eff)) && nx_c_odd && nx_r_odd;
   end

   // filtered pixel from the stored even-row sums
   mbf_pkg::rgb_type avg;
   always_comb begin
      avg.r = mbf_pkg::CH_W'(((mbf_pkg::SUM_W + 1)'(ram_rdata.r) +
                              (mbf_pkg::SUM_W + 1)'(ps_ff.r)) >> 2);
      avg.g = mbf_pkg::CH_W'(((mbf_pkg::SUM_W + 1)'(ram_rdata.g) +
                              (mbf_pkg::SUM_W + 1)'(ps_ff.g)) >> 2);
      avg.b = mbf_pkg::CH_W'(((mbf_pkg::SUM_W + 1)'(ram_rdata.b) +
                              (mbf_pkg::SUM_W + 1)'(ps_ff.b)) >> 2);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      lv_in        = lv_ff;
      cur_in       = cur_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      rsp_load     = 1'b0;
      rsp_word_in  = rsp_word_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_STEP;
               lv_in    = '0;
               cur_in.r = req_word.pixel_in[23:16];
               cur_in.g = req_word.pixel_in[15:8];
               cur_in.b = req_word.pixel_in[7:0];
            end
         end
         ST_STEP: begin
            priority if (term || !c_cur[0]) begin
               state_in = ST_IDLE;
            end else if (!r_cur[0]) begin
               ram_we   = 1'b1;
               state_in = ST_IDLE;
            end else begin
               ram_re   = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (rsp_free) begin
               rsp_load          = 1'b1;
               rsp_word_in.level = mbf_pkg::LEVEL_W'(nx5);
               rsp_word_in.col   = out_col_ff;
               rsp_word_in.row   = out_row_ff;
               rsp_word_in.color = {8'h00, avg};
               rsp_word_in.last  = !more;
               cur_in            = avg;
               lv_in             = nx;
               // the next level always steps its counters on the new pixel
               state_in          = ST_STEP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_stall && rsp_valid_ff);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         size_log2_ff  <= mbf_pkg::SIZE_LOG2_RST;
         max_levels_ff <= mbf_pkg::MAX_LEVELS_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && (csr_index == mbf_pkg::CSR_SIZE_LOG2)) begin
            size_log2_ff <= csr_wdata;
         end
         if (csr_we && (csr_index == mbf_pkg::CSR_MAX_LEVELS)) begin
            max_levels_ff <= csr_wdata;
         end
      end
   end

   // per-level counters and pair holds
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         for (int i = 0; i < MAX_LEVELS; i++) begin
            col_ff[i]  <= '0;
            row_ff[i]  <= '0;
            hold_ff[i] <= '0;
         end
      end else if (state_ff == ST_STEP) begin
         col_ff[lv_ff] <= col_next;
         row_ff[lv_ff] <= row_next;
         if (!term && !c_cur[0]) begin
            hold_ff[lv_ff] <= cur_ff;
         end
      end
   end

   // working payload
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      lv_ff       <= lv_in;
      rsp_word_ff <= rsp_word_in;
      if (ram_re) begin
         ps_ff      <= ps;
         out_col_ff <= mbf_pkg::POS_W'(c_cur >> 1);
         out_row_ff <= mbf_pkg::POS_W'(r_cur >> 1);
      end
   end

   // even-row pair sums, one window per level
   mbf_ram #(
      .WIDTH (PSW),
      .DEPTH (DEPTH)
   ) u_row_sums (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_addr),
      .wr_data (ps),
      .rd_en   (ram_re),
      .rd_addr (ram_addr),
      .rd_data (ram_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

// ----- rtl/core/mbf_checker.sv -----
// port-level checks for the mipmap filter chain, bound to the top level
`default_nettype none

`include "mipmap_box_filter_chain_top_macros.svh"

module mbf_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire mbf_pkg::rsp_word_type rsp_word
);

   // a stalled result word holds
   `MBF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word), "stalled result word changed")

   // reset leaves no result pending and the input open
   `MBF_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && !req_stall, "block not idle after reset")

   // an accepted word keeps the block busy for its level step
   `MBF_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, req_stall, "input open right after accept")

   // a new result only comes out of a busy cycle
   `MBF_ASSERT_NOW(a_rsp_from_work, clock, reset, $rose(rsp_valid), $past(req_stall), "result appeared without work")

endmodule

bind mipmap_box_filter_chain_top mbf_checker u_mbf_checker (.*);

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// testbench for the mipmap box filter chain: directed table, framed random words, scoreboard
`default_nettype none

module tb_top;

   localparam int MAX_SIDE      = 11;
   localparam int NUM_LEVELS    = 12;
   localparam int SETTLE_CYCLES = 40;
   localparam int RAND_WORDS    = 335;
   localparam int HOLD_CYCLES   = 300;
   localparam int N_DIR         = 29;
   localparam int N_PHASES      = 10;

   // ten-bit channel sums of a pixel pair or of a 2x2 block
   typedef struct packed {
      logic [9:0] r;
      logic [9:0] g;
      logic [9:0] b;
   } chan_sum_type;

   // one line of the directed table: a register write or a pixel word
   typedef struct packed {
      logic                          is_cfg;
      logic [mbf_pkg::CSR_IDX_W-1:0] idx;
      logic [mbf_pkg::CFG_W-1:0]     val;
      logic [mbf_pkg::PIX_W-1:0]     pixel;
      logic                          start;
      logic                          typed;
      mbf_pkg::rsp_word_type         want;
   } dir_row_type;

   localparam mbf_pkg::rsp_word_type NO_WANT    = '0;
   localparam mbf_pkg::rsp_word_type WANT_WHITE =
      '{4'd1, 10'd0, 10'd0, 32'h00FF_FFFF, 1'b1};
   localparam mbf_pkg::rsp_word_type WANT_BLACK =
      '{4'd1, 10'd0, 10'd0, 32'h0000_0000, 1'b1};

   localparam dir_row_type DIR_ROWS [N_DIR] = '{
      // reset size, no block completes
      '{1'b0, mbf_pkg::CSR_SIZE_LOG2, 4'd0, 32'h0000_0000, 1'b1, 1'b0, NO_WANT},
      '{1'b0, mbf_pkg::CSR_SIZE_LOG2, 4'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_WANT},
      '{1'b0, mbf_pkg::CSR_SIZE_LOG2, 4'd0, 32'h8040_2010, 1'b0, 1'b0, NO_WANT},
      // side 2: one block per image
      '{1'b1, mbf_pkg::CSR_SIZE_LOG2, 4'd1, 32'h0000_0000, 1'b0, 1'b0, NO_WANT},
      '{1'b0, mbf_pkg::CSR_SIZE_LOG2, 4'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_WANT},
      '{1'b0, mbf_pkg::CSR_SIZE_LOG2, 4'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_WANT},
      '{1'b0, mbf_pkg::CSR_SIZE_LOG2, 4'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_WANT},
      '{1'b0, mbf_pkg::CSR_SIZE_LOG2, 4'd0, 32'hFFFF_FFFF, 1'b0, 1'b1, WANT_WHITE},
      // image wraps with no frame start
      '{1'b0, mbf_pkg::CSR_SIZE_LOG2, 4'd0, 32'h0000_0000, 1'b0, 1'b0, NO_WANT},
      '{1'b0, mbf_pkg::CSR_SIZE_LOG2, 4'd0, 32'h0000_0000, 1'b0, 1'b0, NO_WANT},
      '{1'b0, mbf_pkg::CSR_SIZE_LOG2, 4'd0, 32'h0000_0000, 1'b0, 1'b0, NO_WANT},
      '{1'b0, mbf_pkg::CSR_SIZE_LOG2, 4'd0, 32'h0000_0000, 1'b0, 1'b1, WANT_BLACK},
      // partial image abandoned by a frame start
      '{1'b0, mbf_pkg::CSR_SIZE_LOG2, 4'd0, 32'h1234_5678, 1'b1, 1'b0, NO_WANT},
      '{1'b0, mbf_pkg::CSR_SIZE_LOG2, 4'd0, 32'h00FF_00FF, 1'b0, 1'b0, NO_WANT},
      // alpha ignored, truncating mean
      '{1'b0, mbf_pkg::CSR_SIZE_LOG2, 4'd0, 32'hFF01_0203, 1'b1, 1'b0, NO_WANT},
      '{1'b0, mbf_pkg::CSR_SIZE_LOG2, 4'd0, 32'h0004_0506, 1'b0, 1'b0, NO_WANT},
      '{1'b0, mbf_pkg::CSR_SIZE_LOG2, 4'd0, 32'hAB07_0809, 1'b0, 1'b0, NO_WANT},
      '{1'b0, mbf_pkg::CSR_SIZE_LOG2, 4'd0, 32'h000A_0B0C, 1'b0, 1'b0, NO_WANT},
      // base side of 1
      '{1'b1, mbf_pkg::CSR_SIZE_LOG2, 4'd0, 32'h0000_0000, 1'b0, 1'b0, NO_WANT},
      '{1'b0, mbf_pkg::CSR_SIZE_LOG2, 4'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, NO_WANT},
      '{1'b0, mbf_pkg::CSR_SIZE_LOG2, 4'd0, 32'h0000_0000, 1'b0, 1'b0, NO_WANT},
      // size above range saturates
      '{1'b1, mbf_pkg::CSR_SIZE_LOG2, 4'd15, 32'h0000_0000, 1'b0, 1'b0, NO_WANT},
      '{1'b0, mbf_pkg::CSR_SIZE_LOG2, 4'd0, 32'h5A5A_A5A5, 1'b1, 1'b0, NO_WANT},
      // level limit zero gives no output
      '{1'b1, mbf_pkg::CSR_SIZE_LOG2, 4'd1, 32'h0000_0000, 1'b0, 1'b0, NO_WANT},
      '{1'b1, mbf_pkg::CSR_MAX_LEVELS, 4'd0, 32'h0000_0000, 1'b0, 1'b0, NO_WANT},
      '{1'b0, mbf_pkg::CSR_SIZE_LOG2, 4'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, NO_WANT},
      '{1'b0, mbf_pkg::CSR_SIZE_LOG2, 4'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_WANT},
      '{1'b0, mbf_pkg::CSR_SIZE_LOG2, 4'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_WANT},
      '{1'b0, mbf_pkg::CSR_SIZE_LOG2, 4'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_WANT}
   };

   localparam int PHASE_SIZE   [N_PHASES] = '{2, 3, 1, 4, 3, 2, 1, 3, 2, 1};
   localparam int PHASE_LEVELS [N_PHASES] = '{12, 12, 1, 15, 2, 0, 12, 3, 12, 1};

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   mbf_pkg::req_word_type         req_word = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   mbf_pkg::rsp_word_type         rsp_word;
   logic                          csr_we = 1'b0;
   logic [mbf_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [mbf_pkg::CFG_W-1:0]     csr_wdata = '0;

   mipmap_box_filter_chain_top #(
      .MAX_SIDE_LOG2 (MAX_SIDE),
      .MAX_LEVELS    (NUM_LEVELS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // chain model state
   logic [mbf_pkg::CFG_W-1:0] cfg_size;
   logic [mbf_pkg::CFG_W-1:0] cfg_levels;
   chan_sum_type              row_acc [NUM_LEVELS][1024];
   mbf_pkg::rgb_type          pair_hold [NUM_LEVELS];
   int                        lvl_col [NUM_LEVELS];
   int                        lvl_row [NUM_LEVELS];
   mbf_pkg::rsp_word_type     step_res [MAX_SIDE];

   // mip pixels still owed by the block, oldest first
   mbf_pkg::rsp_word_type     mip_expect [$];
   mbf_pkg::rsp_word_type     oldest;
   int                        words_sent = 0;
   int                        mips_seen = 0;
   int                        fails = 0;
   int                        hold_left = 0;
   bit                        hold_asked = 1'b0;
   bit                        hold_done = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   // drop partial image: counters and pair holds back to zero
   task automatic chain_restart();
      for (int lv = 0; lv < NUM_LEVELS; lv++) begin
         lvl_col[lv] = 0;
         lvl_row[lv] = 0;
         pair_hold[lv] = '0;
      end
   endtask

   // feed one base pixel through the level cascade, mip pixels land in step_res
   task automatic mip_predict(input logic [mbf_pkg::PIX_W-1:0] pixel, input logic start,
                              output int n);
      int               s, ml, lv, side_log, side, c, r, oc;
      mbf_pkg::rgb_type cur;
      chan_sum_type     ps, t;
      bit               done;
      s = (cfg_size > MAX_SIDE) ? MAX_SIDE : int'(cfg_size);
      ml = (cfg_levels > NUM_LEVELS) ? NUM_LEVELS : int'(cfg_levels);
      if (ml == 0) ml = 1;
      n = 0;
      if (start) chain_restart();
      cur = pixel[23:0];
      for (lv = 0; lv < NUM_LEVELS; lv++) begin
         if (lv > s) break;
         side_log = s - lv;
         side = 1 << side_log;
         c = lvl_col[lv];
         r = lvl_row[lv];
         if (c >= side) c = 0;
         if (r >= side) r = 0;
         // step this level's raster position
         if (c + 1 >= side) begin
            lvl_col[lv] = 0;
            lvl_row[lv] = (r + 1 >= side) ? 0 : r + 1;
         end else begin
            lvl_col[lv] = c + 1;
            lvl_row[lv] = r;
         end
         if (side_log == 0 || lv + 1 >= ml) break;
         done = 1'b0;
         if (c % 2 == 0) begin
            pair_hold[lv] = cur;
         end else begin
            oc = c / 2;
            ps.r = 10'(pair_hold[lv].r) + 10'(cur.r);
            ps.g = 10'(pair_hold[lv].g) + 10'(cur.g);
            ps.b = 10'(pair_hold[lv].b) + 10'(cur.b);
            if (r % 2 == 0) begin
               row_acc[lv][oc] = ps;
            end else begin
               // odd row closes the 2x2 block
               t = row_acc[lv][oc];
               cur.r = 8'((int'(t.r) + int'(ps.r)) >> 2);
               cur.g = 8'((int'(t.g) + int'(ps.g)) >> 2);
               cur.b = 8'((int'(t.b) + int'(ps.b)) >> 2);
               step_res[n] = '{4'(lv + 1), 10'(oc), 10'(r / 2), {8'h00, cur}, 1'b0};
               n++;
               done = 1'b1;
            end
         end
         if (!done) break;
      end
      if (n > 0) step_res[n - 1].last = 1'b1;
   endtask

   // wait for the block to go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (mip_expect.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [mbf_pkg::CSR_IDX_W-1:0] idx,
                            input logic [mbf_pkg::CFG_W-1:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_we <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == mbf_pkg::CSR_SIZE_LOG2) cfg_size = val;
      else if (idx == mbf_pkg::CSR_MAX_LEVELS) cfg_levels = val;
      chain_restart();
      @(posedge clock);
   endtask

   // offer one pixel word, then record what it should produce
   task automatic send_word(input logic [mbf_pkg::PIX_W-1:0] pixel, input logic start,
                            input logic typed, input mbf_pkg::rsp_word_type want);
      int n;
      while (!(words_sent >= 150 && words_sent < 230) && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= '{pixel_in: pixel, frame_start: start};
      do @(posedge clock); while (req_stall);
      words_sent++;
      mip_predict(pixel, start, n);
      if (typed) mip_expect.push_back(want);
      else for (int i = 0; i < n; i++) mip_expect.push_back(step_res[i]);
   endtask

   // result side: scoreboard and stall pattern
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (mip_expect.size() == 0) begin
            $error("unexpected word: level %0d col %0d row %0d color %h",
                   rsp_word.level, rsp_word.col, rsp_word.row, rsp_word.color);
            fails++;
         end else begin
            oldest = mip_expect.pop_front();
            if (rsp_word.level !== oldest.level) begin
               $error("level: expected %0d, got %0d", oldest.level, rsp_word.level);
               fails++;
            end
            if (rsp_word.col !== oldest.col) begin
               $error("col: expected %0d, got %0d", oldest.col, rsp_word.col);
               fails++;
            end
            if (rsp_word.row !== oldest.row) begin
               $error("row: expected %0d, got %0d", oldest.row, rsp_word.row);
               fails++;
            end
            if (rsp_word.color !== oldest.color) begin
               $error("color: expected %h, got %h", oldest.color, rsp_word.color);
               fails++;
            end
            if (rsp_word.last !== oldest.last) begin
               $error("last: expected %0d, got %0d", oldest.last, rsp_word.last);
               fails++;
            end
         end
         mips_seen++;
      end
      // one long hold-off on request, otherwise random stalls with a quiet stretch
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_asked && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (mips_seen >= 60 && mips_seen < 110) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 23);
      end
   end

   // stimulus
   initial begin
      int                        ph, sz, ml, flen, nframes, len, rand_words;
      logic                      start;
      logic [mbf_pkg::PIX_W-1:0] px;
      bit                        broke;
      cfg_size = mbf_pkg::SIZE_LOG2_RST;
      cfg_levels = mbf_pkg::MAX_LEVELS_RST;
      chain_restart();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int k = 0; k < N_DIR; k++) begin
         if (DIR_ROWS[k].is_cfg) begin
            settle();
            write_reg(DIR_ROWS[k].idx, DIR_ROWS[k].val);
         end else begin
            send_word(DIR_ROWS[k].pixel, DIR_ROWS[k].start, DIR_ROWS[k].typed,
                      DIR_ROWS[k].want);
         end
      end

      // random images, one register setting per phase
      rand_words = 0;
      ph = 0;
      while (rand_words < RAND_WORDS) begin
         settle();
         if (ph < N_PHASES) begin
            sz = PHASE_SIZE[ph];
            ml = PHASE_LEVELS[ph];
         end else begin
            sz = $urandom_range(3, 1);
            ml = $urandom_range(15, 0);
         end
         write_reg(mbf_pkg::CSR_SIZE_LOG2, 4'(sz));
         write_reg(mbf_pkg::CSR_MAX_LEVELS, 4'(ml));
         if (ph == 1) hold_asked = 1'b1;
         flen = 1 << (2 * sz);
         if (flen > 128) flen = 128;
         nframes = (sz <= 2) ? 2 : 1;
         broke = 1'b1;
         for (int f = 0; f < nframes; f++) begin
            // mostly whole images, sometimes cut short
            len = ($urandom_range(9) == 0) ? $urandom_range(flen - 1, 1) : flen;
            for (int i = 0; i < len && rand_words < RAND_WORDS; i++) begin
               if (i == 0) start = broke ? 1'b1 : 1'($urandom_range(1));
               else start = ($urandom_range(49) == 0);
               case ($urandom_range(9))
                  0: px = '0;
                  1: px = '1;
                  default: px = $urandom;
               endcase
               send_word(px, start, 1'b0, NO_WANT);
               rand_words++;
            end
            broke = (len < flen);
         end
         ph++;
      end

      settle();
      if (fails == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/mbf_pkg.sv
rtl/core/mbf_ram.sv
rtl/core/mipmap_box_filter_chain_top.sv
rtl/core/mbf_checker.sv
tb/sv/tb_top.sv
